@@ rtl/core/mafs_pkg.sv @@
// shared types, codes and header lookup tables for the mpeg audio frame sync
package mafs_pkg;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_CRC = 2'd1;
    localparam logic [1:0] KIND_PAY = 2'd2;

    localparam logic [10:0] SYNC_WORD = 11'h7FF;
    localparam logic [1:0]  VER_RSVD  = 2'd1;
    localparam logic [1:0]  VER_MPEG1 = 2'd3;
    localparam logic [1:0]  LC_RSVD   = 2'd0;
    localparam logic [1:0]  LC_L3     = 2'd1;
    localparam logic [1:0]  LC_L1     = 2'd3;

    localparam int unsigned DIV_STEPS = 12;
    localparam int unsigned NUM_W     = 27;

    typedef struct packed {
        logic       accept;
        logic       div_step;
        logic       len_load;
        logic       hdr_emit;
        logic [1:0] hdr_idx;
    } mafs_cmd_t;

    typedef struct packed {
        logic hdr_found;
        logic out_free;
    } mafs_stat_t;

    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lc,
                                               input logic [3:0] bi);
        logic [8:0] r;
        r = 9'd0;
        if (ver == VER_MPEG1) begin
            case (lc)
                LC_L1: begin
                    case (bi)
                        4'd1: r = 9'd32;   4'd2: r = 9'd64;   4'd3: r = 9'd96;
                        4'd4: r = 9'd128;  4'd5: r = 9'd160;  4'd6: r = 9'd192;
                        4'd7: r = 9'd224;  4'd8: r = 9'd256;  4'd9: r = 9'd288;
                        4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
                        4'd13: r = 9'd416; 4'd14: r = 9'd448;
                        default: r = 9'd0;
                    endcase
                end
                2'd2: begin
                    case (bi)
                        4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
                        4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
                        4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd160;
                        4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
                        4'd13: r = 9'd320; 4'd14: r = 9'd384;
                        default: r = 9'd0;
                    endcase
                end
                LC_L3: begin
                    case (bi)
                        4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
                        4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
                        4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
                        4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
                        4'd13: r = 9'd256; 4'd14: r = 9'd320;
                        default: r = 9'd0;
                    endcase
                end
                default: r = 9'd0;
            endcase
        end else begin
            case (lc)
                LC_L1: begin
                    case (bi)
                        4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
                        4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
                        4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd144;
                        4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
                        4'd13: r = 9'd224; 4'd14: r = 9'd256;
                        default: r = 9'd0;
                    endcase
                end
                2'd2, LC_L3: begin
                    case (bi)
                        4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
                        4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
                        4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
                        4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
                        4'd13: r = 9'd144; 4'd14: r = 9'd160;
                        default: r = 9'd0;
                    endcase
                end
                default: r = 9'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] si);
        logic [15:0] r;
        r = 16'd0;
        case (ver)
            2'd0: begin
                case (si)
                    2'd0: r = 16'd11025; 2'd1: r = 16'd12000; 2'd2: r = 16'd8000;
                    default: r = 16'd0;
                endcase
            end
            2'd2: begin
                case (si)
                    2'd0: r = 16'd22050; 2'd1: r = 16'd24000; 2'd2: r = 16'd16000;
                    default: r = 16'd0;
                endcase
            end
            2'd3: begin
                case (si)
                    2'd0: r = 16'd44100; 2'd1: r = 16'd48000; 2'd2: r = 16'd32000;
                    default: r = 16'd0;
                endcase
            end
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // bytes-per-slot factor times 1000: 12 for layer I, 72 for half-rate layer III, else 144
    function automatic logic [17:0] fmul_lookup(input logic [1:0] ver, input logic [1:0] lc);
        logic [17:0] r;
        if (lc == LC_L1)
            r = 18'd12000;
        else if (lc == LC_L3 && ver != VER_MPEG1)
            r = 18'd72000;
        else
            r = 18'd144000;
        return r;
    endfunction

    function automatic logic [17:0] dur_lookup(input logic [1:0] ver, input logic [1:0] lc,
                                               input logic [1:0] si);
        logic [15:0] sr;
        logic [17:0] r;
        sr = rate_lookup(ver, si);
        r  = 18'd0;
        if (lc == LC_L1) begin
            case (sr)
                16'd44100: r = 18'd8707;   16'd48000: r = 18'd8000;
                16'd32000: r = 18'd12000;  16'd22050: r = 18'd17414;
                16'd24000: r = 18'd16000;  16'd16000: r = 18'd24000;
                16'd11025: r = 18'd34829;  16'd12000: r = 18'd32000;
                16'd8000:  r = 18'd48000;
                default:   r = 18'd0;
            endcase
        end else if (lc == LC_L3 && ver != VER_MPEG1) begin
            case (sr)
                16'd22050: r = 18'd26122;  16'd24000: r = 18'd24000;
                16'd16000: r = 18'd36000;  16'd11025: r = 18'd52244;
                16'd12000: r = 18'd48000;  16'd8000:  r = 18'd72000;
                default:   r = 18'd0;
            endcase
        end else begin
            case (sr)
                16'd44100: r = 18'd26122;  16'd48000: r = 18'd24000;
                16'd32000: r = 18'd36000;  16'd22050: r = 18'd52244;
                16'd24000: r = 18'd48000;  16'd16000: r = 18'd72000;
                16'd11025: r = 18'd104489; 16'd12000: r = 18'd96000;
                16'd8000:  r = 18'd144000;
                default:   r = 18'd0;
            endcase
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mpeg_audio_frame_sync.sv @@
// top level of the mpeg audio frame synchronizer
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_stall    data_byte
//   out       source      out_valid / out_stall  frame_byte .. frame_duration_us
//
// hunting and in-frame bytes are taken back to back while the output is free
// a found header runs the restoring divider for the frame length, then loads the
// counters, then emits four beats of header bytes
// rst_n clears window, counters and output valid asynchronously
// input is stalled while the output register holds an untaken beat or a header is in work
module mpeg_audio_frame_sync
    import mafs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic [1:0]  byte_kind,
    output logic        frame_end,
    output logic [1:0]  version_id,
    output logic [1:0]  layer_num,
    output logic        crc_present,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [3:0]  channel_bits,
    output logic [5:0]  misc_bits,
    output logic [11:0] frame_length,
    output logic [17:0] frame_duration_us
);

    mafs_cmd_t  cmd;
    mafs_stat_t stat;

    mafs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mafs_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_byte        (frame_byte),
        .byte_kind         (byte_kind),
        .frame_end         (frame_end),
        .version_id        (version_id),
        .layer_num         (layer_num),
        .crc_present       (crc_present),
        .bitrate_kbps      (bitrate_kbps),
        .sample_rate_hz    (sample_rate_hz),
        .channel_bits      (channel_bits),
        .misc_bits         (misc_bits),
        .frame_length      (frame_length),
        .frame_duration_us (frame_duration_us)
    );

endmodule

@@ rtl/core/mafs_ctrl.sv @@
// sequencer: byte accept, length division, header burst
module mafs_ctrl
    import mafs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  mafs_stat_t stat,
    output mafs_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LEN,
        ST_HDR
    } state_t;

    state_t     state_reg;
    logic [3:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       accept;

    assign in_stall = !(state_reg == ST_IDLE && stat.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd.accept   = accept;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.len_load = (state_reg == ST_LEN);
        cmd.hdr_emit = (state_reg == ST_HDR) && stat.out_free;
        cmd.hdr_idx  = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && stat.hdr_found)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= 4'd0;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(DIV_STEPS - 1))
                        state_reg <= ST_LEN;
                end
                ST_LEN:
                begin
                    idx_reg   <= 2'd0;
                    state_reg <= ST_HDR;
                end
                ST_HDR:
                begin
                    if (stat.out_free)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/mafs_dp.sv @@
// datapath: sync window, header latch, length divider, frame counters, output register
module mafs_dp
    import mafs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mafs_cmd_t   cmd,
    output mafs_stat_t  stat,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic [1:0]  byte_kind,
    output logic        frame_end,
    output logic [1:0]  version_id,
    output logic [1:0]  layer_num,
    output logic        crc_present,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [3:0]  channel_bits,
    output logic [5:0]  misc_bits,
    output logic [11:0] frame_length,
    output logic [17:0] frame_duration_us
);

    logic [23:0]      window_reg;
    logic [1:0]       fill_reg;
    logic             in_frame_reg;
    logic [11:0]      bytes_left_reg;
    logic [1:0]       crc_left_reg;
    logic [31:0]      hdr_reg;
    logic [11:0]      len_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvs_reg;
    logic [11:0]      quo_reg;
    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic [1:0]       kind_reg;
    logic             end_reg;
    logic [31:0]      hdr_out_reg;
    logic [11:0]      len_out_reg;

    logic [31:0]      cand;
    logic             cand_ok;
    logic [NUM_W-1:0] num;
    logic [11:0]      bl_dec;
    logic [11:0]      len_calc;
    logic [11:0]      q_pad;
    logic             rem_ge;
    logic             load_out;
    logic [7:0]       hdr_byte;
    logic             hdr_last_end;

    assign cand = {window_reg, data_byte};

    always_comb
    begin
        cand_ok = (cand[31:21] == SYNC_WORD) && (cand[20:19] != VER_RSVD)
               && (cand[18:17] != LC_RSVD)
               && (kbps_lookup(cand[20:19], cand[18:17], cand[15:12]) != 9'd0)
               && (rate_lookup(cand[20:19], cand[11:10]) != 16'd0);
    end

    assign stat.hdr_found = !in_frame_reg && (fill_reg == 2'd3) && cand_ok;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign num = NUM_W'(kbps_lookup(cand[20:19], cand[18:17], cand[15:12]))
               * NUM_W'(fmul_lookup(cand[20:19], cand[18:17]));

    assign rem_ge = (rem_reg >= dvs_reg);
    assign bl_dec = (bytes_left_reg != 12'd0) ? bytes_left_reg - 12'd1 : 12'd0;
    assign q_pad  = quo_reg + {11'd0, hdr_reg[9]};
    // layer I counts four-byte slots
    assign len_calc = (hdr_reg[18:17] == LC_L1) ? {q_pad[9:0], 2'b00} : q_pad;

    always_comb
    begin
        case (cmd.hdr_idx)
            2'd0:    hdr_byte = hdr_reg[31:24];
            2'd1:    hdr_byte = hdr_reg[23:16];
            2'd2:    hdr_byte = hdr_reg[15:8];
            default: hdr_byte = hdr_reg[7:0];
        endcase
    end

    assign hdr_last_end = (cmd.hdr_idx == 2'd3) && (bytes_left_reg == 12'd0);
    assign load_out     = (cmd.accept && in_frame_reg) || cmd.hdr_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= 24'd0;
            fill_reg       <= 2'd0;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 12'd0;
            crc_left_reg   <= 2'd0;
            hdr_reg        <= 32'd0;
            len_reg        <= 12'd0;
            rem_reg        <= '0;
            dvs_reg        <= '0;
            quo_reg        <= 12'd0;
            out_valid_reg  <= 1'b0;
            byte_reg       <= 8'd0;
            kind_reg       <= KIND_HDR;
            end_reg        <= 1'b0;
            hdr_out_reg    <= 32'd0;
            len_out_reg    <= 12'd0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.accept)
            begin
                if (in_frame_reg)
                begin
                    byte_reg       <= data_byte;
                    kind_reg       <= (crc_left_reg != 2'd0) ? KIND_CRC : KIND_PAY;
                    end_reg        <= (bl_dec == 12'd0);
                    hdr_out_reg    <= hdr_reg;
                    len_out_reg    <= len_reg;
                    bytes_left_reg <= bl_dec;
                    if (bl_dec == 12'd0)
                    begin
                        in_frame_reg <= 1'b0;
                        crc_left_reg <= 2'd0;
                        window_reg   <= 24'd0;
                        fill_reg     <= 2'd0;
                    end
                    else if (crc_left_reg != 2'd0)
                        crc_left_reg <= crc_left_reg - 2'd1;
                end
                else if (fill_reg != 2'd3)
                begin
                    window_reg <= cand[23:0];
                    fill_reg   <= fill_reg + 2'd1;
                end
                else if (!cand_ok)
                begin
                    window_reg <= cand[23:0];
                end
                else
                begin
                    hdr_reg    <= cand;
                    window_reg <= 24'd0;
                    fill_reg   <= 2'd0;
                    rem_reg    <= num;
                    dvs_reg    <= {rate_lookup(cand[20:19], cand[11:10]), 11'd0};
                    quo_reg    <= 12'd0;
                end
            end

            // restoring division, one quotient bit per divider step
            if (cmd.div_step)
            begin
                if (rem_ge)
                    rem_reg <= rem_reg - dvs_reg;
                quo_reg <= {quo_reg[10:0], rem_ge};
                dvs_reg <= {1'b0, dvs_reg[NUM_W-1:1]};
            end

            if (cmd.len_load)
            begin
                len_reg        <= len_calc;
                bytes_left_reg <= (len_calc > 12'd4) ? len_calc - 12'd4 : 12'd0;
                crc_left_reg   <= hdr_reg[16] ? 2'd0 : 2'd2;
            end

            if (cmd.hdr_emit)
            begin
                byte_reg    <= hdr_byte;
                kind_reg    <= KIND_HDR;
                end_reg     <= hdr_last_end;
                hdr_out_reg <= hdr_reg;
                len_out_reg <= len_reg;
                if (cmd.hdr_idx == 2'd3)
                begin
                    in_frame_reg <= (bytes_left_reg != 12'd0);
                    if (bytes_left_reg == 12'd0)
                        crc_left_reg <= 2'd0;
                end
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_byte        = byte_reg;
    assign byte_kind         = kind_reg;
    assign frame_end         = end_reg;
    assign version_id        = hdr_out_reg[20:19];
    assign layer_num         = 2'(3'd4 - {1'b0, hdr_out_reg[18:17]});
    assign crc_present       = ~hdr_out_reg[16];
    assign bitrate_kbps      = kbps_lookup(hdr_out_reg[20:19], hdr_out_reg[18:17],
                                           hdr_out_reg[15:12]);
    assign sample_rate_hz    = rate_lookup(hdr_out_reg[20:19], hdr_out_reg[11:10]);
    assign channel_bits      = hdr_out_reg[7:4];
    assign misc_bits         = {hdr_out_reg[9:8], hdr_out_reg[3:0]};
    assign frame_length      = len_out_reg;
    assign frame_duration_us = dur_lookup(hdr_out_reg[20:19], hdr_out_reg[18:17],
                                          hdr_out_reg[11:10]);

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for the mpeg audio frame synchronizer
`timescale 1ns / 100ps

module tb_top
    import mafs_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic [1:0]  byte_kind;
    logic        frame_end;
    logic [1:0]  version_id;
    logic [1:0]  layer_num;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [3:0]  channel_bits;
    logic [5:0]  misc_bits;
    logic [11:0] frame_length;
    logic [17:0] frame_duration_us;

    typedef struct packed {
        logic [7:0]  fbyte;
        logic [1:0]  kind;
        logic        fend;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic        crc;
        logic [8:0]  kbps;
        logic [15:0] rate;
        logic [3:0]  chan;
        logic [5:0]  misc;
        logic [11:0] flen;
        logic [17:0] dur;
    } frame_beat_t;

    mpeg_audio_frame_sync uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .frame_byte(frame_byte), .byte_kind(byte_kind), .frame_end(frame_end),
        .version_id(version_id), .layer_num(layer_num), .crc_present(crc_present),
        .bitrate_kbps(bitrate_kbps), .sample_rate_hz(sample_rate_hz),
        .channel_bits(channel_bits), .misc_bits(misc_bits),
        .frame_length(frame_length), .frame_duration_us(frame_duration_us)
    );

    // predictor state
    logic [23:0] win;
    int unsigned win_cnt;
    logic        framing;
    int unsigned remain;
    int unsigned crc_cnt;
    logic [31:0] cur_hdr;
    logic [11:0] cur_len;

    frame_beat_t expected_beats[$];
    int          errors;
    int          beats_seen;
    int          frames_seen;
    int          items_sent;
    longint      cycles;
    logic        hold_off;

    localparam longint CYCLE_LIMIT = 2000000;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned rate_of(logic [1:0] ver, logic [1:0] si);
        int unsigned base;
        case (si)
            2'd0: base = 44100;
            2'd1: base = 48000;
            2'd2: base = 32000;
            default: return 0;
        endcase
        case (ver)
            VER_MPEG1: return base;
            2'd2: return base / 2;
            2'd0: return base / 4;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned kbps_of(logic [1:0] ver, logic [1:0] lc, logic [3:0] bi);
        int unsigned t1[16] = '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0};
        int unsigned t2[16] = '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0};
        int unsigned t3[16] = '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0};
        int unsigned h1[16] = '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0};
        int unsigned h2[16] = '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0};
        if (lc == LC_RSVD)
            return 0;
        if (ver == VER_MPEG1)
            return lc == LC_L1 ? t1[bi] : (lc == 2'd2 ? t2[bi] : t3[bi]);
        return lc == LC_L1 ? h1[bi] : h2[bi];
    endfunction

    function automatic bit header_ok(logic [31:0] h);
        if (h[31:21] != SYNC_WORD || h[20:19] == VER_RSVD || h[18:17] == LC_RSVD)
            return 0;
        return kbps_of(h[20:19], h[18:17], h[15:12]) != 0 && rate_of(h[20:19], h[11:10]) != 0;
    endfunction

    function automatic logic [11:0] length_of(logic [31:0] h);
        longint unsigned br, sr, f;
        br = longint'(kbps_of(h[20:19], h[18:17], h[15:12])) * 1000;
        sr = rate_of(h[20:19], h[11:10]);
        if (h[18:17] == LC_L1)
            return 12'(((12 * br) / sr + h[9]) * 4);
        f = (h[18:17] == LC_L3 && h[20:19] != VER_MPEG1) ? 72 : 144;
        return 12'((f * br) / sr + h[9]);
    endfunction

    function automatic frame_beat_t make_beat(logic [7:0] b, logic [1:0] k, logic e);
        frame_beat_t r;
        longint unsigned n, sr;
        sr = rate_of(cur_hdr[20:19], cur_hdr[11:10]);
        if (cur_hdr[18:17] == LC_L1)
            n = 384;
        else if (cur_hdr[18:17] == LC_L3 && cur_hdr[20:19] != VER_MPEG1)
            n = 576;
        else
            n = 1152;
        r.fbyte = b;
        r.kind  = k;
        r.fend  = e;
        r.ver   = cur_hdr[20:19];
        r.lay   = 2'(4 - cur_hdr[18:17]);
        r.crc   = ~cur_hdr[16];
        r.kbps  = 9'(kbps_of(cur_hdr[20:19], cur_hdr[18:17], cur_hdr[15:12]));
        r.rate  = 16'(sr);
        r.chan  = cur_hdr[7:4];
        r.misc  = {cur_hdr[9:8], cur_hdr[3:0]};
        r.flen  = cur_len;
        r.dur   = sr == 0 ? 18'd0 : 18'((n * 1000000) / sr);
        return r;
    endfunction

    task automatic predict_sync(input logic [7:0] b);
        logic [31:0] h;
        logic [1:0]  k;
        if (framing)
        begin
            if (crc_cnt > 0)
            begin
                k = KIND_CRC;
                crc_cnt--;
            end
            else
                k = KIND_PAY;
            if (remain > 0)
                remain--;
            expected_beats.push_back(make_beat(b, k, remain == 0));
            if (remain == 0)
            begin
                framing = 0;
                crc_cnt = 0;
                win = 0;
                win_cnt = 0;
            end
            return;
        end
        if (win_cnt < 3)
        begin
            win = {win[15:0], b};
            win_cnt++;
            return;
        end
        h = {win, b};
        if (!header_ok(h))
        begin
            win = h[23:0];
            return;
        end
        cur_hdr = h;
        cur_len = length_of(h);
        crc_cnt = h[16] ? 0 : 2;
        remain  = cur_len > 4 ? cur_len - 4 : 0;
        win = 0;
        win_cnt = 0;
        frames_seen++;
        for (int i = 0; i < 4; i++)
            expected_beats.push_back(make_beat(h[31-8*i -: 8], KIND_HDR,
                                               i == 3 && remain == 0));
        framing = remain != 0;
        if (!framing)
            crc_cnt = 0;
    endtask

    function automatic int unsigned short_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // valid stays high between back-to-back bytes, the caller drops it when done
    task automatic send_byte(input logic [7:0] b, input bit gaps);
        int unsigned g;
        g = gaps ? short_gap() : 0;
        repeat (g)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sync(b);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // legal header no longer than max_len bytes: random fields unless pinned
    function automatic logic [31:0] random_header(input int unsigned max_len);
        logic [31:0] h;
        do
        begin
            h = $urandom;
            h[31:21] = SYNC_WORD;
            // low bitrates mostly
            if ($urandom_range(0, 4) != 0)
                h[15:12] = 4'($urandom_range(1, 3));
        end while (!header_ok(h) || length_of(h) > max_len);
        return h;
    endfunction

    task automatic send_frame(input logic [31:0] h, input bit gaps);
        int unsigned n;
        n = length_of(h);
        for (int i = 0; i < 4; i++)
            send_byte(h[31-8*i -: 8], gaps);
        for (int i = 4; i < n; i++)
            send_byte(8'($urandom), gaps);
    endtask

    task automatic test_directed();
        // window fill, then one invalid header of each kind
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hEB, 0);
        send_byte(8'h10, 0);
        send_byte(8'h00, 0);       // version code reserved
        send_byte(8'hFF, 0);
        send_byte(8'hF9, 0);
        send_byte(8'h10, 0);
        send_byte(8'h00, 0);       // layer code reserved
        send_byte(8'hFF, 0);
        send_byte(8'hFB, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);       // free format bitrate
        send_byte(8'hFF, 0);
        send_byte(8'hFB, 0);
        send_byte(8'hF0, 0);
        send_byte(8'h00, 0);       // bitrate index 15
        send_byte(8'hFF, 0);
        send_byte(8'hFB, 0);
        send_byte(8'h1C, 0);
        send_byte(8'h00, 0);       // sampling index 3
        wait_drained();
        // mpeg-2 layer III 8k @ 24kHz, crc, emphasis 2, half-rate slot factor
        send_frame(32'hFFF2_14F6, 0);
        // mpeg-2.5 layer III 8k @ 12kHz
        send_frame(32'hFFE3_1400, 0);
        // mpeg-1 layer I 32k @ 48kHz with padding
        send_frame(32'hFFFF_16FF, 0);
        wait_drained();
    endtask

    task automatic test_random_stream();
        logic [31:0] h;
        while (items_sent < 250)
        begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1);
                1:
                begin
                    // broken sequence: sync then garbage
                    h = random_header(48);
                    send_byte(h[31:24], 1);
                    send_byte(h[23:16], 1);
                    send_byte(8'($urandom), 1);
                end
                default: send_frame(random_header(48), 1);
            endcase
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        // receiver holds off while sender keeps offering
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_frame(random_header(48), 0);
        join
        wait_drained();
        send_frame(random_header(48), 1);
        wait_drained();
    endtask

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0) ||
                         ($urandom_range(0, 63) == 0 ? 1'b1 : 1'b0);
    end

    always @(posedge clk)
    begin
        frame_beat_t want, got;
        cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{frame_byte, byte_kind, frame_end, version_id, layer_num, crc_present,
                    bitrate_kbps, sample_rate_hz, channel_bits, misc_bits,
                    frame_length, frame_duration_us};
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (want != got)
                begin
                    $display("%0t beat mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d beats pending", $time, expected_beats.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        hold_off = 1'b0;
        errors = 0;
        beats_seen = 0;
        frames_seen = 0;
        items_sent = 0;
        cycles = 0;
        win = 0;
        win_cnt = 0;
        framing = 0;
        remain = 0;
        crc_cnt = 0;
        cur_hdr = 0;
        cur_len = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_stream();
        $display("bytes sent %0d, frames synced %0d, beats checked %0d",
                 items_sent, frames_seen, beats_seen);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mafs_pkg.sv
rtl/core/mafs_ctrl.sv
rtl/core/mafs_dp.sv
rtl/core/mpeg_audio_frame_sync.sv
test/tb_top.sv
